// ===== src/trws_pkg.sv =====
// ============================================================================
// trws_pkg
// Shared codes and constants for the timed register write sequencer.
// ============================================================================
package trws_pkg;

	// input operation codes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// play status codes
	localparam logic [1:0] STAT_NONE  = 2'd0;
	localparam logic [1:0] STAT_DELAY = 2'd1;
	localparam logic [1:0] STAT_WRITE = 2'd2;
	localparam logic [1:0] STAT_END   = 2'd3;

	// delay tag marking in the event high byte
	localparam logic [7:0] TAG_BIT  = 8'h80;
	localparam logic [7:0] TAG_MASK = 8'h7F;

	// configuration register indexes
	localparam logic REG_EVENT_COUNT = 1'b0;

	localparam int EV_W    = 24;
	localparam int DELAY_W = 23;
	localparam int TICK_W  = 32;
	localparam int CFG_W   = 11;

	typedef logic [EV_W-1:0] event_t;

	typedef struct packed {
		logic [14:0]        addr;
		logic [7:0]         val;
		logic [1:0]         status;
		logic [DELAY_W-1:0] delay;
		logic [TICK_W-1:0]  used;
	} result_t;

endpackage

// ===== src/timed_register_write_sequencer_unit.sv =====
// ============================================================================
// timed_register_write_sequencer_unit
// Plays back a stored score of register writes and delay tags against ticks.
// ============================================================================
// Usage notes
//  - Input channel (in_valid/in_ready): one transfer carries an operation.
//    Write stores a 3-byte event at slot, restart rewinds playback, advance
//    offers tick_count elapsed ticks. Only an advance yields a result.
//  - Output channel (out_valid/out_ready): one transfer per advance with the
//    emitted write (if any), play status, remaining delay and ticks used.
//  - APB port: register 0 at byte address 0 is event_count (11 bits,
//    saturated to EVENT_DEPTH). Writing it also rewinds playback.
//  - Sequencing: write and restart complete in the idle state. An advance
//    moves from its transfer through ST_STEP, then ST_EVAL and back for
//    every event read from the store, and ends in ST_HOLD before out_valid;
//    the walk is bound by the single read port of the event store (one read
//    issued, then evaluated, per event).
//  - A fresh input transfer is taken once the previous advance has placed
//    its result in the output register, even if that result is not yet
//    taken; the next result then waits until out_ready frees the register.
//  - Reset: playback position, pending delay and event_count clear to zero.
//    The event store is not cleared; only written slots may be played.
//  - Stall: a held result stays on the output ports until taken.
// ============================================================================
module timed_register_write_sequencer_unit
	import trws_pkg::*;
#(
	parameter int EVENT_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [9:0]  slot,
	input  logic [7:0]  event_high_byte,
	input  logic [7:0]  event_low_byte,
	input  logic [7:0]  event_data_byte,
	input  logic [31:0] tick_count,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] write_address,
	output logic [7:0]  write_value,
	output logic [1:0]  play_status,
	output logic [22:0] delay_left,
	output logic [31:0] ticks_used
);

	localparam int IDX_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int POS_W = $clog2(EVENT_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,  // spend ticks, issue store read
		ST_EVAL,  // decode event read back
		ST_HOLD   // hand result to output register
	} state_t;

	state_t              state_q;
	logic [POS_W-1:0]    count_q;
	logic [POS_W-1:0]    pos_q;
	logic [DELAY_W-1:0]  wait_q;
	logic [TICK_W-1:0]   pending_q;
	logic [TICK_W-1:0]   ticks_q;
	result_t             res_q;
	result_t             out_q;
	logic                out_valid_q;

	// event store
	event_t              store_mem [EVENT_DEPTH];
	event_t              rd_data_q;
	logic                mem_we;
	logic                mem_re;
	logic [IDX_W-1:0]    wr_idx;
	logic [31:0]         slot_ext;

	logic                in_fire;
	logic                cfg_wr;
	logic [31:0]         cfg_v32;
	logic [POS_W-1:0]    cfg_count;
	logic                hold_go;

	logic                spend_ge;
	logic [TICK_W-1:0]   pend_sp;
	logic [DELAY_W-1:0]  wait_sp;
	logic                has_event;
	logic [7:0]          ev_hi;
	logic                ev_tag;
	logic [DELAY_W-1:0]  ev_delay;

	assign pready    = 1'b1;
	assign prdata    = 32'(count_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_EVENT_COUNT);

	// result moves to the output register once that register is free
	assign hold_go   = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	// saturate event_count to the store depth
	assign cfg_v32   = 32'(pwdata[CFG_W-1:0]);
	assign cfg_count = (cfg_v32 > 32'(EVENT_DEPTH)) ? POS_W'(EVENT_DEPTH) : POS_W'(cfg_v32);

	assign slot_ext  = 32'(slot);
	assign wr_idx    = slot_ext[IDX_W-1:0];
	assign mem_we    = in_fire && (operation == OP_WRITE) && (slot_ext < 32'(EVENT_DEPTH));

	// spend offered ticks against the pending delay
	always_comb begin
		spend_ge = (pending_q >= TICK_W'(wait_q));
		if (spend_ge) begin
			pend_sp = pending_q - TICK_W'(wait_q);
			wait_sp = '0;
		end else begin
			pend_sp = '0;
			wait_sp = wait_q - DELAY_W'(pending_q);
		end
	end

	assign has_event = (pos_q < count_q);
	assign mem_re    = (state_q == ST_STEP) && (wait_sp == '0) && has_event;

	assign ev_hi    = rd_data_q[23:16];
	assign ev_tag   = ((ev_hi & TAG_BIT) != 8'd0);
	assign ev_delay = {ev_hi[6:0] & TAG_MASK[6:0], rd_data_q[15:0]};

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[wr_idx] <= {event_high_byte, event_low_byte, event_data_byte};
		end
		if (mem_re) begin
			rd_data_q <= store_mem[pos_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
			pending_q   <= '0;
			ticks_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (hold_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				count_q <= cfg_count;
				pos_q   <= '0;
				wait_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (operation == OP_RESTART) begin
							if (!cfg_wr) begin
								pos_q  <= '0;
								wait_q <= '0;
							end
						end else if (operation == OP_ADVANCE) begin
							pending_q <= tick_count;
							ticks_q   <= tick_count;
							state_q   <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					pending_q <= pend_sp;
					wait_q    <= wait_sp;
					if (wait_sp != '0) begin
						res_q   <= '{addr: '0, val: '0, status: STAT_DELAY,
							delay: wait_sp, used: ticks_q};
						state_q <= ST_HOLD;
					end else if (has_event) begin
						res_q   <= '{addr: '0, val: '0, status: STAT_NONE,
							delay: '0, used: ticks_q};
						pos_q   <= pos_q + POS_W'(1);
						state_q <= ST_EVAL;
					end else begin
						res_q   <= '{addr: '0, val: '0, status: STAT_END,
							delay: '0, used: ticks_q};
						state_q <= ST_HOLD;
					end
				end
				ST_EVAL: begin
					if (!ev_tag) begin
						res_q   <= '{addr: rd_data_q[22:8], val: rd_data_q[7:0],
							status: STAT_WRITE, delay: '0, used: ticks_q - pending_q};
						state_q <= ST_HOLD;
					end else begin
						// zero delay tags are stepped over
						wait_q  <= ev_delay;
						res_q   <= '{addr: '0, val: '0,
							status: (ev_delay != '0) ? STAT_DELAY : STAT_NONE,
							delay: ev_delay, used: ticks_q};
						state_q <= (pending_q != '0) ? ST_STEP : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (hold_go) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = out_q.addr;
	assign write_value   = out_q.val;
	assign play_status   = out_q.status;
	assign delay_left    = out_q.delay;
	assign ticks_used    = out_q.used;

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= count_q)
		else $error("play position beyond event count");

	a_eval_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_STEP)
		else $error("event decoded without a store read");

	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != STAT_WRITE |-> out_q.addr == '0 && out_q.val == '0)
		else $error("write fields set without an emitted write");

	a_delay_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != STAT_DELAY |-> out_q.delay == '0)
		else $error("delay left without delay status");

	a_no_input_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !mem_we)
		else $error("store written during playback walk");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Checks the timed register write sequencer unit: scores are loaded into the
// event store, event_count is set over APB while the unit is quiet, and tick
// advances are played against a cycle-free predictor of the playback walk.
// A short stimulus table covers the corner cases; random traffic follows
// under three idling patterns, a long output stall and a full drain.
// ============================================================================
module testbench;
	import trws_pkg::*;

	localparam int STORE_DEPTH    = 1024;
	localparam int RX_HOLD_CYCLES = 400;
	// the limit must outlast the longest walk over a full store of delay tags
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DIR_ROWS       = 22;

	// operation three is undefined and must be ignored
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [2:0] EVENT_COUNT_ADDR = {REG_EVENT_COUNT, 2'b00};
	localparam result_t NO_RES = '0;

	// one row of the directed table; cfg sets event_count before the row
	typedef struct packed {
		logic              cfg;
		logic [CFG_W-1:0]  count;
		logic [1:0]        op;
		logic [9:0]        sl;
		logic [7:0]        hi;
		logic [7:0]        lo;
		logic [7:0]        dat;
		logic [TICK_W-1:0] ticks;
		logic              pinned;
		result_t           res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_WRITE;
	logic [9:0]  slot = '0;
	logic [7:0]  event_high_byte = '0;
	logic [7:0]  event_low_byte = '0;
	logic [7:0]  event_data_byte = '0;
	logic [31:0] tick_count = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [14:0] write_address;
	logic [7:0]  write_value;
	logic [1:0]  play_status;
	logic [22:0] delay_left;
	logic [31:0] ticks_used;

	// expected result typed into the table, travels with the transfer
	logic    pin_en = 1'b0;
	result_t pin_res = '0;

	// predictor state
	logic [EV_W-1:0]    score_mem [STORE_DEPTH];
	logic [CFG_W-1:0]   score_len = '0;
	logic [CFG_W-1:0]   play_pos = '0;
	logic [DELAY_W-1:0] wait_left = '0;
	result_t            advance_results [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          rx_hold_req = 1'b0;
	int unsigned rx_hold_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned fails = 0;
	int unsigned cur_len = 0;

	dir_row_t dir_table [DIR_ROWS] = '{
		// after reset nothing is scored: end of score, every tick used
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF,
			1'b1, '{15'd0, 8'd0, STAT_END, 23'd0, 32'hFFFF_FFFF}},
		'{1'b0, 11'd0, OP_NOP, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, NO_RES},
		// short score: zero tag, extreme write, longest tag, zero write, ...
		'{1'b0, 11'd0, OP_WRITE, 10'd0, 8'h80, 8'h00, 8'h00, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd1, 8'h7F, 8'hFF, 8'hFF, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd2, 8'hFF, 8'hFF, 8'hFF, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd3, 8'h00, 8'h00, 8'h00, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd4, 8'h80, 8'h00, 8'h05, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd5, 8'h80, 8'h00, 8'h00, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd6, 8'h12, 8'h34, 8'h56, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'd7, 8'h80, 8'h00, 8'h03, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_WRITE, 10'h3FF, 8'h55, 8'hAA, 8'h0F, 32'd0, 1'b0, NO_RES},
		// zero tag with no ticks left stops with status none
		'{1'b1, 11'd8, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd0,
			1'b1, '{15'd0, 8'd0, STAT_NONE, 23'd0, 32'd0}},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd0,
			1'b1, '{15'h7FFF, 8'hFF, STAT_WRITE, 23'd0, 32'd0}},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd1, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd2, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd10, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd1, 1'b0, NO_RES},
		// runs off the end of the score: all offered ticks count as used
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'd5,
			1'b1, '{15'd0, 8'd0, STAT_END, 23'd0, 32'd5}},
		'{1'b0, 11'd0, OP_RESTART, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 32'd0, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_ADVANCE, 10'd0, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b0, NO_RES},
		'{1'b0, 11'd0, OP_NOP, 10'd0, 8'h00, 8'h00, 8'h00, 32'd0, 1'b0, NO_RES}
	};

	timed_register_write_sequencer_unit #(
		.EVENT_DEPTH(STORE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.slot(slot),
		.event_high_byte(event_high_byte),
		.event_low_byte(event_low_byte),
		.event_data_byte(event_data_byte),
		.tick_count(tick_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.write_address(write_address),
		.write_value(write_value),
		.play_status(play_status),
		.delay_left(delay_left),
		.ticks_used(ticks_used)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor of one advance: spend ticks on the pending delay, then walk
	// through delay tags until a write is emitted, ticks run out or the
	// score ends. Updates play_pos and wait_left.
	// ------------------------------------------------------------------
	function automatic result_t advance_playback(input logic [TICK_W-1:0] ticks);
		logic [TICK_W-1:0] pending;
		logic [EV_W-1:0]   ev;
		result_t           r;
		bit                done;

		pending = ticks;
		r = '0;
		r.used = ticks;
		done = 1'b0;
		do begin
			if (pending >= TICK_W'(wait_left)) begin
				pending = pending - TICK_W'(wait_left);
				wait_left = '0;
			end else begin
				wait_left = wait_left - pending[DELAY_W-1:0];
				pending = '0;
			end
			r.addr = '0;
			r.val = '0;
			r.status = STAT_NONE;
			if (wait_left != '0) begin
				r.status = STAT_DELAY;
			end else if (play_pos < score_len) begin
				ev = score_mem[play_pos];
				play_pos = play_pos + 1'b1;
				if ((ev[23:16] & TAG_BIT) != '0) begin
					// zero-length tags are stepped over silently
					if ({ev[22:16] & TAG_MASK[6:0], ev[15:0]} != '0) begin
						wait_left = {ev[22:16] & TAG_MASK[6:0], ev[15:0]};
						r.status = STAT_DELAY;
					end
				end else begin
					r.addr = ev[22:8];
					r.val = ev[7:0];
					r.status = STAT_WRITE;
					r.used = ticks - pending;
					done = 1'b1;
				end
			end else begin
				r.status = STAT_END;
				done = 1'b1;
			end
		end while (!done && pending != '0);
		r.delay = wait_left;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: register writes and input transfers update the predictor,
	// output transfers are checked against the oldest expected result.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t want;

		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == EVENT_COUNT_ADDR) begin
				// saturates at the store depth; a write also rewinds playback
				score_len = (pwdata[CFG_W-1:0] > CFG_W'(STORE_DEPTH)) ?
					CFG_W'(STORE_DEPTH) : pwdata[CFG_W-1:0];
				play_pos = '0;
				wait_left = '0;
			end
			if (in_valid && in_ready) begin
				case (operation)
					OP_WRITE: begin
						score_mem[slot] = {event_high_byte, event_low_byte, event_data_byte};
					end
					OP_RESTART: begin
						play_pos = '0;
						wait_left = '0;
					end
					OP_ADVANCE: begin
						want = advance_playback(tick_count);
						advance_results.push_back(pin_en ? pin_res : want);
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (advance_results.size() == 0) begin
					$error("result transfer with no advance outstanding");
					fails++;
				end else begin
					want = advance_results.pop_front();
					check_field("write_address", 32'(want.addr), 32'(write_address));
					check_field("write_value", 32'(want.val), 32'(write_value));
					check_field("play_status", 32'(want.status), 32'(play_status));
					check_field("delay_left", 32'(want.delay), 32'(delay_left));
					check_field("ticks_used", want.used, ticks_used);
				end
			end
		end
	end

	// no transfer on either channel for too long means the unit is hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, or a long hold-off when requested so
	// that the unit fills up and stalls its input.
	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			rx_hold_left = rx_hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Called at a falling edge; returns at the falling edge after the
	// transfer, leaving valid high so items can go back to back.
	task automatic send_item(input logic [1:0] op, input logic [9:0] sl,
			input logic [EV_W-1:0] ev, input logic [TICK_W-1:0] ticks,
			input logic pinned, input result_t res);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		slot <= sl;
		event_high_byte <= ev[23:16];
		event_low_byte <= ev[15:8];
		event_data_byte <= ev[7:0];
		tick_count <= ticks;
		pin_en <= pinned;
		pin_res <= res;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// sender pause: nothing offered until every result has come back
	task automatic wait_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (advance_results.size() != 0)
			@(negedge clk);
	endtask

	// event_count is only written with the unit quiet; write and restart
	// transfers leave no result, so pause for them to retire before the write
	task automatic set_event_count(input logic [31:0] value);
		wait_results();
		repeat (8) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= EVENT_COUNT_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_len = (value[CFG_W-1:0] > CFG_W'(STORE_DEPTH)) ?
			STORE_DEPTH : int'(value[CFG_W-1:0]);
	endtask

	// mostly writes, some short tags, a few zero and long tags
	function automatic logic [EV_W-1:0] random_event();
		int unsigned r;

		r = $urandom_range(99);
		if (r < 60)
			return {1'b0, 7'($urandom), 8'($urandom), 8'($urandom)};
		else if (r < 82)
			return {TAG_BIT, 8'h00, 8'($urandom_range(15))};
		else if (r < 95)
			return {TAG_BIT, 16'h0000};
		else
			return {1'b1, 7'($urandom), 8'($urandom), 8'($urandom)};
	endfunction

	function automatic logic [TICK_W-1:0] random_ticks();
		int unsigned r;

		r = $urandom_range(99);
		if (r < 40)
			return TICK_W'($urandom_range(8));
		else if (r < 65)
			return TICK_W'($urandom_range(64));
		else if (r < 75)
			return '0;
		else if (r < 85)
			return TICK_W'($urandom_range(32'h0100_0000));
		else if (r < 95)
			return TICK_W'($urandom);
		else
			return '1;
	endfunction

	// slots are filled before event_count can reach them, so playback never
	// reads an entry that was not written
	task automatic fill_score(input int first, input int last);
		for (int i = first; i < last; i++)
			send_item(OP_WRITE, 10'(i), random_event(), random_ticks(), 1'b0, NO_RES);
	endtask

	task automatic run_mix(input int n);
		int unsigned r;
		logic [9:0]  sl;

		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			sl = 10'($urandom_range(STORE_DEPTH - 1));
			if (r < 55) begin
				send_item(OP_ADVANCE, sl, random_event(), random_ticks(), 1'b0, NO_RES);
			end else if (r < 80) begin
				// half the writes rework the score being played
				if (cur_len != 0 && $urandom_range(1) == 1)
					sl = 10'($urandom_range(cur_len - 1));
				send_item(OP_WRITE, sl, random_event(), random_ticks(), 1'b0, NO_RES);
			end else if (r < 92) begin
				send_item(OP_RESTART, sl, random_event(), random_ticks(), 1'b0, NO_RES);
			end else begin
				send_item(OP_NOP, sl, random_event(), random_ticks(), 1'b0, NO_RES);
			end
		end
	endtask

	initial begin : stimulus
		dir_row_t row;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// sender idles 37 %, receiver 51 %
		tx_idle_pct = 37;
		rx_idle_pct = 51;
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_table[i];
			if (row.cfg)
				set_event_count(32'(row.count));
			send_item(row.op, row.sl, {row.hi, row.lo, row.dat}, row.ticks,
				row.pinned, row.res);
		end

		fill_score(8, 48);
		set_event_count(48);
		run_mix(60);
		// long output stall while the sender keeps offering
		rx_hold_req = 1'b1;
		run_mix(100);
		wait_results();
		run_mix(60);

		// idling swapped; whole store in play, count saturates
		tx_idle_pct = 51;
		rx_idle_pct = 37;
		fill_score(48, STORE_DEPTH);
		set_event_count(32'hFFFF_FFFF);
		run_mix(100);

		// no idling at all
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_event_count(0);
		run_mix(20);
		set_event_count(STORE_DEPTH);
		run_mix(100);
		set_event_count($urandom_range(64, 1));
		run_mix(40);

		wait_results();
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
